### src/tdsw_pkg.sv
// Shared types, constants and sequencing functions of the two-wire display serial writer.
package tdsw_pkg;

    localparam logic [7:0] CMD_DATA_WRITE = 8'h40;
    localparam logic [7:0] CTRL_RESET     = 8'h8A;

    localparam logic [2:0] HOLD_NONE  = 3'd0;
    localparam logic [2:0] HOLD_SHORT = 3'd2;
    localparam logic [2:0] HOLD_BIT   = 3'd3;
    localparam logic [2:0] HOLD_ACK   = 3'd5;

    typedef enum logic [1:0] {
        FUNC_OPEN       = 2'd0,
        FUNC_DATA       = 2'd1,
        FUNC_DATA_CLOSE = 2'd2,
        FUNC_CLOSE      = 2'd3
    } tdsw_func_t;

    typedef enum logic [2:0] {
        SEG_START    = 3'd0,
        SEG_BYTE0    = 3'd1,
        SEG_BYTE1    = 3'd2,
        SEG_ACK      = 3'd3,
        SEG_STOP     = 3'd4,
        SEG_END_LOW  = 3'd5,
        SEG_END_HIGH = 3'd6
    } tdsw_seg_t;

    // One classified request as it waits in the queue.
    typedef struct packed {
        tdsw_func_t func;
        logic [7:0] byte0;
        logic [7:0] byte1;
    } tdsw_cmd_t;

    // Segment program of each request kind.
    function automatic tdsw_seg_t seg_kind(input tdsw_func_t func, input logic [2:0] idx);
        tdsw_seg_t kind;
        kind = SEG_END_LOW;
        unique case (func)
            FUNC_OPEN:
                unique case (idx)
                    3'd0:    kind = SEG_START;
                    3'd1:    kind = SEG_BYTE0;
                    3'd2:    kind = SEG_ACK;
                    3'd3:    kind = SEG_STOP;
                    3'd4:    kind = SEG_START;
                    3'd5:    kind = SEG_BYTE1;
                    3'd6:    kind = SEG_ACK;
                    default: kind = SEG_END_LOW;
                endcase
            FUNC_DATA:
                unique case (idx)
                    3'd0:    kind = SEG_BYTE0;
                    3'd1:    kind = SEG_ACK;
                    default: kind = SEG_END_LOW;
                endcase
            FUNC_DATA_CLOSE:
                unique case (idx)
                    3'd0:    kind = SEG_BYTE0;
                    3'd1:    kind = SEG_ACK;
                    3'd2:    kind = SEG_STOP;
                    3'd3:    kind = SEG_START;
                    3'd4:    kind = SEG_BYTE1;
                    3'd5:    kind = SEG_ACK;
                    3'd6:    kind = SEG_STOP;
                    default: kind = SEG_END_HIGH;
                endcase
            FUNC_CLOSE:
                unique case (idx)
                    3'd0:    kind = SEG_STOP;
                    3'd1:    kind = SEG_START;
                    3'd2:    kind = SEG_BYTE0;
                    3'd3:    kind = SEG_ACK;
                    3'd4:    kind = SEG_STOP;
                    default: kind = SEG_END_HIGH;
                endcase
        endcase
        return kind;
    endfunction

    // Index of the final pin step within a segment.
    function automatic logic [3:0] seg_last(input tdsw_seg_t kind);
        logic [3:0] n;
        unique case (kind)
            SEG_START:    n = 4'd1;
            SEG_BYTE0:    n = 4'd15;
            SEG_BYTE1:    n = 4'd15;
            SEG_ACK:      n = 4'd1;
            SEG_STOP:     n = 4'd2;
            SEG_END_LOW:  n = 4'd0;
            SEG_END_HIGH: n = 4'd0;
            default:      n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

### src/tdsw_if.sv
// Channel interfaces: request input, pin step output and configuration write.
interface tdsw_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] value;
    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface tdsw_step_if;
    logic       valid;
    logic       ready;
    logic       clk_level;
    logic       dio_level;
    logic [2:0] hold_units;
    logic       last;
    modport source (output valid, output clk_level, output dio_level, output hold_units,
                    output last, input ready);
    modport sink   (input valid, input clk_level, input dio_level, input hold_units,
                    input last, output ready);
endinterface

interface tdsw_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/tdsw_front.sv
// Front end: control register, request classification and a two-entry command queue.
module tdsw_front (
    input  logic                 clk,
    input  logic                 rst_n,
    tdsw_req_if.sink             req,
    tdsw_cfg_if.sink             cfg,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output tdsw_pkg::tdsw_cmd_t  cmd
);

    logic [7:0]          display_control_reg;
    tdsw_pkg::tdsw_cmd_t entry_reg [2];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          count_reg, count_next;
    tdsw_pkg::tdsw_cmd_t new_cmd;
    tdsw_pkg::tdsw_func_t func;
    logic                push, pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_control_reg <= tdsw_pkg::CTRL_RESET;
        end
        else if (cfg.valid)
        begin
            display_control_reg <= cfg.data;
        end
    end

    // Pick the two bytes that the back end will shift out.
    always_comb
    begin
        func = tdsw_pkg::tdsw_func_t'(req.func);
        new_cmd.func = func;
        unique case (func)
            tdsw_pkg::FUNC_OPEN:
            begin
                new_cmd.byte0 = tdsw_pkg::CMD_DATA_WRITE;
                new_cmd.byte1 = req.value;
            end
            tdsw_pkg::FUNC_DATA, tdsw_pkg::FUNC_DATA_CLOSE:
            begin
                new_cmd.byte0 = req.value;
                new_cmd.byte1 = display_control_reg;
            end
            default:
            begin
                new_cmd.byte0 = display_control_reg;
                new_cmd.byte1 = display_control_reg;
            end
        endcase
    end

    assign req.ready = (count_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    ap_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    ap_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 && !pop |=> count_reg == 2'd2)
        else $error("full queue changed without a pop");

    ap_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> rd_ptr_reg != $past(rd_ptr_reg))
        else $error("read pointer did not advance on pop");

endmodule

### src/tdsw_back.sv
// Back end: segment sequencer that turns one command into registered pin steps.
module tdsw_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  tdsw_pkg::tdsw_cmd_t  cmd,
    tdsw_step_if.source          step
);

    tdsw_pkg::tdsw_cmd_t cmd_reg;
    logic                busy_reg, busy_next;
    logic [2:0]          seg_idx_reg, seg_idx_next;
    logic [3:0]          step_reg, step_next;
    logic                data_line_reg, data_line_next;
    logic                out_valid_reg, out_valid_next;
    logic                clk_level_reg, dio_level_reg, last_reg;
    logic [2:0]          hold_units_reg;

    tdsw_pkg::tdsw_seg_t kind;
    logic                seg_done, is_end, advance, load;
    logic [7:0]          cur_byte;
    logic                cur_bit;
    logic                s_clk, s_dio;
    logic [2:0]          s_hold;

    assign kind     = tdsw_pkg::seg_kind(cmd_reg.func, seg_idx_reg);
    assign seg_done = (step_reg == tdsw_pkg::seg_last(kind));
    assign is_end   = (kind == tdsw_pkg::SEG_END_LOW) || (kind == tdsw_pkg::SEG_END_HIGH);
    assign advance  = busy_reg && (!out_valid_reg || step.ready);
    assign cmd_ready = !busy_reg || (advance && is_end);
    assign load     = cmd_valid && cmd_ready;
    assign cur_byte = (kind == tdsw_pkg::SEG_BYTE1) ? cmd_reg.byte1 : cmd_reg.byte0;
    assign cur_bit  = cur_byte[step_reg[3:1]];

    // Levels of the current pin step and the data line it leaves behind.
    always_comb
    begin
        s_clk          = 1'b0;
        s_dio          = data_line_reg;
        s_hold         = tdsw_pkg::HOLD_NONE;
        data_line_next = data_line_reg;
        unique case (kind)
            tdsw_pkg::SEG_START:
            begin
                s_clk  = 1'b1;
                s_dio  = !step_reg[0];
                s_hold = step_reg[0] ? tdsw_pkg::HOLD_NONE : tdsw_pkg::HOLD_SHORT;
                if (step_reg[0])
                begin
                    data_line_next = 1'b0;
                end
            end
            tdsw_pkg::SEG_BYTE0, tdsw_pkg::SEG_BYTE1:
            begin
                s_clk          = step_reg[0];
                s_dio          = cur_bit;
                s_hold         = tdsw_pkg::HOLD_BIT;
                data_line_next = cur_bit;
            end
            tdsw_pkg::SEG_ACK:
            begin
                s_clk  = step_reg[0];
                s_hold = step_reg[0] ? tdsw_pkg::HOLD_SHORT : tdsw_pkg::HOLD_ACK;
            end
            tdsw_pkg::SEG_STOP:
            begin
                s_clk  = (step_reg == 4'd2);
                s_dio  = (step_reg == 4'd0) ? data_line_reg : 1'b0;
                s_hold = tdsw_pkg::HOLD_SHORT;
                if (step_reg == 4'd2)
                begin
                    data_line_next = 1'b1;
                end
            end
            tdsw_pkg::SEG_END_LOW:
            begin
                s_clk = 1'b0;
            end
            tdsw_pkg::SEG_END_HIGH:
            begin
                s_clk          = 1'b1;
                s_dio          = 1'b1;
                data_line_next = 1'b1;
            end
            default:
            begin
                s_clk = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        seg_idx_next   = seg_idx_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !step.ready;
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (is_end)
            begin
                seg_idx_next = 3'd0;
                step_next    = 4'd0;
            end
            else if (seg_done)
            begin
                seg_idx_next = seg_idx_reg + 3'd1;
                step_next    = 4'd0;
            end
            else
            begin
                step_next = step_reg + 4'd1;
            end
        end
        if (cmd_ready)
        begin
            busy_next = cmd_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            seg_idx_reg   <= 3'd0;
            step_reg      <= 4'd0;
            data_line_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            seg_idx_reg   <= seg_idx_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                data_line_reg <= data_line_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg <= cmd;
        end
        if (advance)
        begin
            clk_level_reg  <= s_clk;
            dio_level_reg  <= s_dio;
            hold_units_reg <= s_hold;
            last_reg       <= is_end;
        end
    end

    assign step.valid      = out_valid_reg;
    assign step.clk_level  = clk_level_reg;
    assign step.dio_level  = dio_level_reg;
    assign step.hold_units = hold_units_reg;
    assign step.last       = last_reg;

    ap_stall_holds_seq: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && out_valid_reg && !step.ready |=> $stable(seg_idx_reg) && $stable(step_reg))
        else $error("sequencer moved while the output stalled");

    ap_step_in_segment: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg <= tdsw_pkg::seg_last(kind))
        else $error("step index beyond its segment");

    ap_mid_item_busy: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !is_end |=> busy_reg)
        else $error("sequencer went idle inside an item");

    ap_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_end |=> seg_idx_reg == 3'd0 && step_reg == 4'd0)
        else $error("sequencer not rewound after the final step");

endmodule

### src/two_wire_display_serial_writer_top.sv
// Top level of the two-wire display serial writer: front end, command queue and step sequencer.
// A request accepted into an empty block passes the command queue and the back end's command
// register before its first pin step is registered. The back end's step sequencer sets the
// throughput of one pin step per cycle unless the output stalls, so request length varies by
// kind (data, close, open, data-and-close). Requests are taken while the sequencer works, up
// to two waiting in the command queue. Reset is asynchronous and active low: queue and
// sequencer empty, the data line is idle high and the display control register returns to 0x8A.
module two_wire_display_serial_writer_top (
    input  logic         clk,
    input  logic         rst_n,
    tdsw_req_if.sink     req,
    tdsw_cfg_if.sink     cfg,
    tdsw_step_if.source  step
);

    // Command hand-over between the two halves. The front end owns the display
    // control register and folds it, or the fixed data-command byte, into each
    // queued command, so the back end never looks at configuration.
    logic                cmd_valid;
    logic                cmd_ready;
    tdsw_pkg::tdsw_cmd_t cmd;

    // The front end accepts one request transfer per cycle while its queue has room.
    tdsw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // The back end walks the segment program of each command (start, byte,
    // acknowledge, stop, end) and emits one registered pin step per cycle while
    // not stalled. It takes the next command in the same cycle as it issues the
    // final step of the current one, so consecutive requests follow without a gap.
    tdsw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .step      (step)
    );

endmodule
